/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BFC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define BFC_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define BFC_ASSERT(lbl, clk, rstn, prop)
`define BFC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/bfc_pkg.sv */
// Package with the constants, types and helper functions of the culling and shading block.
`default_nettype none
package bfc_pkg;
	localparam int VERTEX_DEPTH = 1024;
	localparam int VADDR_W = $clog2(VERTEX_DEPTH);
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int COL_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_COEF = 12;

	localparam logic [1:0] KIND_COEF = 2'd0;
	localparam logic [1:0] KIND_VERTEX = 2'd1;
	localparam logic [1:0] KIND_FACE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE = 2'd2;

	localparam logic [COL_W-1:0] ONE_Q = 17'd65536;

	localparam int DIV_A_W = 60;
	localparam int DIV_B_W = 34;
	localparam int DIV_Q_W = 52;
	localparam int DIV_R_W = 36;
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd52;
	localparam logic [DIV_CNT_W-1:0] SQRT_STEPS = 6'd30;
	localparam logic MODE_DIV = 1'b0;
	localparam logic MODE_SQRT = 1'b1;

	typedef struct packed {
		logic start;
		logic mode;
		logic [DIV_A_W-1:0] a;
		logic [DIV_B_W-1:0] b;
	} du_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_Q_W-1:0] result;
	} du_rsp_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] z;
	} vertex_t;

	function automatic logic signed [31:0] sat32_66(input logic signed [65:0] v);
		if ((v[65:31] == '0) || (v[65:31] == '1)) begin
			return v[31:0];
		end
		return v[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic signed [31:0] sat32_33(input logic signed [32:0] v);
		if (v[32] == v[31]) begin
			return v[31:0];
		end
		return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic fits30(input logic signed [65:0] v);
		return (v[65:29] == '0) || (v[65:29] == '1);
	endfunction
endpackage
`default_nettype wire

/* rtl/bfc_if.sv */
// Handshake interfaces for the input items and the result items.
`default_nettype none
interface bfc_item_if import bfc_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [IDX_W-1:0] index_a;
	logic [IDX_W-1:0] index_b;
	logic [IDX_W-1:0] index_c;
	logic signed [VAL_W-1:0] value_x;
	logic signed [VAL_W-1:0] value_y;
	logic signed [VAL_W-1:0] value_z;
	modport source (output valid, kind, index_a, index_b, index_c, value_x, value_y, value_z,
		input ready);
	modport sink (input valid, kind, index_a, index_b, index_c, value_x, value_y, value_z,
		output ready);
endinterface

interface bfc_result_if import bfc_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] proj_x;
	logic signed [VAL_W-1:0] proj_y;
	logic signed [VAL_W-1:0] proj_z;
	logic [COL_W-1:0] shade_red;
	logic [COL_W-1:0] shade_green;
	logic [COL_W-1:0] shade_blue;
	logic last_vertex;
	modport source (output valid, proj_x, proj_y, proj_z, shade_red, shade_green, shade_blue,
		last_vertex, input ready);
	modport sink (input valid, proj_x, proj_y, proj_z, shade_red, shade_green, shade_blue,
		last_vertex, output ready);
endinterface
`default_nettype wire

/* rtl/bfc_vstore.sv */
// World-space vertex store with one write port and one registered read port.
`default_nettype none
module bfc_vstore import bfc_pkg::*; (
	input wire logic clk,
	input wire logic we,
	input wire logic [VADDR_W-1:0] waddr,
	input wire vertex_t wdata,
	input wire logic [VADDR_W-1:0] raddr,
	output vertex_t rdata
);
	vertex_t mem [VERTEX_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/bfc_divsqrt.sv */
// Shared bit-serial unsigned divider and integer square root unit.
`default_nettype none
module bfc_divsqrt import bfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire du_req_t req,
	output du_rsp_t rsp
);
	logic busy_q, done_q, mode_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_R_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] q_q;
	logic [DIV_A_W-1:0] sr_q;
	logic [DIV_B_W-1:0] b_q;
	logic [DIV_R_W-1:0] shifted, operand, rem_next;
	logic [DIV_R_W:0] cand;
	logic ge;

	always_comb begin
		if (mode_q == MODE_SQRT) begin
			shifted = {rem_q[DIV_R_W-3:0], sr_q[DIV_A_W-1:DIV_A_W-2]};
			operand = DIV_R_W'({q_q, 2'b01});
		end else begin
			shifted = {rem_q[DIV_R_W-2:0], sr_q[DIV_A_W-1]};
			operand = DIV_R_W'(b_q);
		end
		cand = {1'b0, shifted} - {1'b0, operand};
		ge = !cand[DIV_R_W];
		rem_next = ge ? cand[DIV_R_W-1:0] : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= (req.mode == MODE_SQRT) ? SQRT_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			rem_q <= '0;
			q_q <= '0;
			b_q <= req.b;
			sr_q <= (req.mode == MODE_SQRT) ? req.a : {req.a[DIV_Q_W-1:0], 8'b0};
		end else if (busy_q) begin
			rem_q <= rem_next;
			q_q <= {q_q[DIV_Q_W-2:0], ge};
			sr_q <= (mode_q == MODE_SQRT) ? {sr_q[DIV_A_W-3:0], 2'b00} : {sr_q[DIV_A_W-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.result = q_q;
endmodule
`default_nettype wire

/* rtl/backface_cull_flat_shade_top.sv */
// Top level: sequencer, shared multiplier and registers of the culling and shading block.
// A transform item is written directly; a vertex item forms nine products on one multiplier.
// A visible face fetches its vertices on the vertex memory port, runs the normal pass, one root
// and up to ten divisions on the shared bit-serial unit; the three results leave through one
// output register. A culled face finishes after the dot product. One item is worked on at a time.
// Reset clears the control state, sets the identity transform and colors of one; the vertex
// store is not cleared.
`default_nettype none
`include "assert_macros.svh"
module backface_cull_flat_shade_top import bfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bfc_item_if.sink items,
	bfc_result_if.source results,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [COL_W-1:0] cfg_wdata
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_VMUL = 4'd1;
	localparam logic [3:0] ST_VWR = 4'd2;
	localparam logic [3:0] ST_FETCH = 4'd3;
	localparam logic [3:0] ST_EDGE = 4'd4;
	localparam logic [3:0] ST_CROSS = 4'd5;
	localparam logic [3:0] ST_NORM = 4'd6;
	localparam logic [3:0] ST_DOT = 4'd7;
	localparam logic [3:0] ST_SQ = 4'd8;
	localparam logic [3:0] ST_SQRT = 4'd9;
	localparam logic [3:0] ST_MU0 = 4'd10;
	localparam logic [3:0] ST_MU = 4'd11;
	localparam logic [3:0] ST_SHADE = 4'd12;
	localparam logic [3:0] ST_PJ0 = 4'd13;
	localparam logic [3:0] ST_PJW = 4'd14;
	localparam logic [3:0] ST_OUT = 4'd15;

	localparam logic signed [34:0] DEN_BASE = 35'sd655360;
	localparam logic signed [32:0] Z_EYE = 33'sd327680;

	logic [3:0] state_q;
	logic [1:0] row_q, term_q, vi_q, ci_q;
	logic ph_q, out_valid_q, rd_oor_q, neg_q;

	logic signed [VAL_W-1:0] coef_q [NUM_COEF];
	logic [COL_W-1:0] color_q [3];
	logic [IDX_W-1:0] ia_q, ib_q, ic_q;
	logic signed [VAL_W-1:0] vx_q, vy_q, vz_q;
	logic signed [VAL_W-1:0] wv_q [3];
	vertex_t vtx_q [3];
	logic signed [VAL_W-1:0] u_q [3], w_q [3], e_q [3];
	logic signed [65:0] n_q [3];
	logic signed [65:0] acc_q;
	logic signed [63:0] mul_q;
	logic [29:0] len_q;
	logic [COL_W-1:0] mu_q;
	logic [COL_W-1:0] shade_q [3];
	logic signed [VAL_W-1:0] proj_q [3];
	logic signed [VAL_W-1:0] o_x_q, o_y_q, o_z_q;
	logic [COL_W-1:0] o_r_q, o_g_q, o_b_q;
	logic o_last_q;

	logic signed [VAL_W-1:0] ma, mb;
	logic signed [65:0] sum_full, sum_shift;
	logic [IDX_W-1:0] rd_idx;
	logic rd_inrange, wr_inrange;
	vertex_t rdata, wdata, pv;
	du_req_t du_req;
	du_rsp_t du_rsp;
	logic signed [51:0] num;
	logic signed [34:0] den;
	logic [51:0] num_abs;
	logic [33:0] den_abs;
	logic signed [35:0] m11;
	logic signed [VAL_W-1:0] pcoord, q_sat;
	logic [29:0] nz_abs;
	logic fits_all, accept, out_free;

	bfc_vstore u_vstore (
		.clk(clk),
		.we(state_q == ST_VWR && wr_inrange),
		.waddr(VADDR_W'(ia_q)),
		.wdata(wdata),
		.raddr(VADDR_W'(rd_idx)),
		.rdata(rdata)
	);

	bfc_divsqrt u_divsqrt (
		.clk(clk),
		.arst_n(arst_n),
		.req(du_req),
		.rsp(du_rsp)
	);

	assign accept = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || results.ready;
	assign wr_inrange = (32'(ia_q) < VERTEX_DEPTH);
	assign rd_inrange = (32'(rd_idx) < VERTEX_DEPTH);
	assign wdata = '{x: wv_q[0], y: wv_q[1], z: wv_q[2]};
	assign sum_full = acc_q + {{2{mul_q[63]}}, mul_q};
	assign sum_shift = acc_q + {{18{mul_q[63]}}, mul_q[63:16]};
	assign fits_all = fits30(n_q[0]) && fits30(n_q[1]) && fits30(n_q[2]);
	assign nz_abs = n_q[2][29] ? 30'(-n_q[2][29:0]) : n_q[2][29:0];

	always_comb begin
		case (row_q)
			2'd0: rd_idx = ia_q;
			2'd1: rd_idx = ib_q;
			default: rd_idx = ic_q;
		endcase
		case (vi_q)
			2'd0: pv = vtx_q[0];
			2'd1: pv = vtx_q[1];
			default: pv = vtx_q[2];
		endcase
		case (ci_q)
			2'd0: pcoord = pv.x;
			2'd1: pcoord = pv.y;
			default: pcoord = pv.z;
		endcase
		m11 = (36'(pcoord) <<< 3) + (36'(pcoord) <<< 1) + 36'(pcoord);
		if (ci_q == 2'd2) begin
			num = 52'({33'(pv.z) - Z_EYE, 16'b0});
			num = {{3{num[48]}}, num[48:0]};
		end else begin
			num = {m11, 16'b0};
		end
		den = DEN_BASE - (35'(pv.z) <<< 1);
		num_abs = num[51] ? 52'(-num) : num;
		den_abs = den[34] ? 34'(-den) : den[33:0];
		if (neg_q) begin
			q_sat = (du_rsp.result > 52'h8000_0000) ? 32'sh8000_0000
				: 32'(-du_rsp.result[31:0]);
		end else begin
			q_sat = (du_rsp.result > 52'h7fff_ffff) ? 32'sh7fff_ffff
				: du_rsp.result[31:0];
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_VMUL: begin
				ma = coef_q[{row_q, term_q}];
				case (term_q)
					2'd0: mb = vx_q;
					2'd1: mb = vy_q;
					default: mb = vz_q;
				endcase
			end
			ST_CROSS: begin
				case ({row_q, term_q[0]})
					3'b000: begin ma = u_q[1]; mb = w_q[2]; end
					3'b001: begin ma = u_q[2]; mb = w_q[1]; end
					3'b010: begin ma = u_q[2]; mb = w_q[0]; end
					3'b011: begin ma = u_q[0]; mb = w_q[2]; end
					3'b100: begin ma = u_q[0]; mb = w_q[1]; end
					default: begin ma = u_q[1]; mb = w_q[0]; end
				endcase
			end
			ST_DOT: begin
				case (row_q)
					2'd0: begin ma = n_q[0][31:0]; mb = e_q[0]; end
					2'd1: begin ma = n_q[1][31:0]; mb = e_q[1]; end
					default: begin ma = n_q[2][31:0]; mb = e_q[2]; end
				endcase
			end
			ST_SQ: begin
				case (row_q)
					2'd0: begin ma = n_q[0][31:0]; mb = n_q[0][31:0]; end
					2'd1: begin ma = n_q[1][31:0]; mb = n_q[1][31:0]; end
					default: begin ma = n_q[2][31:0]; mb = n_q[2][31:0]; end
				endcase
			end
			ST_SHADE: begin
				case (row_q)
					2'd0: ma = 32'(color_q[0]);
					2'd1: ma = 32'(color_q[1]);
					default: ma = 32'(color_q[2]);
				endcase
				mb = 32'(mu_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		du_req.start = 1'b0;
		du_req.mode = MODE_DIV;
		du_req.a = DIV_A_W'(num_abs);
		du_req.b = den_abs;
		case (state_q)
			ST_SQ: begin
				du_req.start = ph_q && (row_q == 2'd2);
				du_req.mode = MODE_SQRT;
				du_req.a = sum_full[DIV_A_W-1:0];
			end
			ST_MU0: begin
				du_req.start = (len_q != '0);
				du_req.a = DIV_A_W'({nz_abs, 16'b0});
				du_req.b = DIV_B_W'(len_q);
			end
			ST_PJ0: begin
				du_req.start = (den != '0);
			end
			default: begin
				du_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
		rd_oor_q <= !rd_inrange;
		if (accept) begin
			ia_q <= items.index_a;
			ib_q <= items.index_b;
			ic_q <= items.index_c;
			vx_q <= items.value_x;
			vy_q <= items.value_y;
			vz_q <= items.value_z;
		end
		case (state_q)
			ST_VMUL: begin
				if (ph_q) begin
					if (term_q == 2'd2) begin
						wv_q[row_q] <= sat32_66(sum_shift + 66'(coef_q[{row_q, 2'd3}]));
						acc_q <= '0;
					end else begin
						acc_q <= sum_shift;
					end
				end
			end
			ST_FETCH: begin
				if (row_q != 2'd0) begin
					vtx_q[0] <= vtx_q[1];
					vtx_q[1] <= vtx_q[2];
					vtx_q[2] <= rd_oor_q ? '0 : rdata;
				end
			end
			ST_EDGE: begin
				u_q[0] <= sat32_33(33'(vtx_q[1].x) - 33'(vtx_q[0].x));
				u_q[1] <= sat32_33(33'(vtx_q[1].y) - 33'(vtx_q[0].y));
				u_q[2] <= sat32_33(33'(vtx_q[1].z) - 33'(vtx_q[0].z));
				w_q[0] <= sat32_33(33'(vtx_q[2].x) - 33'(vtx_q[0].x));
				w_q[1] <= sat32_33(33'(vtx_q[2].y) - 33'(vtx_q[0].y));
				w_q[2] <= sat32_33(33'(vtx_q[2].z) - 33'(vtx_q[0].z));
				e_q[0] <= sat32_33(-33'(vtx_q[0].x));
				e_q[1] <= sat32_33(-33'(vtx_q[0].y));
				e_q[2] <= sat32_33(Z_EYE - 33'(vtx_q[0].z));
				acc_q <= '0;
			end
			ST_CROSS: begin
				if (ph_q) begin
					if (term_q == 2'd0) begin
						acc_q <= {{2{mul_q[63]}}, mul_q};
					end else begin
						n_q[row_q] <= acc_q - {{2{mul_q[63]}}, mul_q};
					end
				end
			end
			ST_NORM: begin
				if (!fits_all) begin
					n_q[0] <= n_q[0] >>> 1;
					n_q[1] <= n_q[1] >>> 1;
					n_q[2] <= n_q[2] >>> 1;
				end
				acc_q <= '0;
			end
			ST_DOT, ST_SQ: begin
				if (ph_q) begin
					acc_q <= (row_q == 2'd2) ? '0 : sum_full;
				end
			end
			ST_SQRT: begin
				if (du_rsp.done) begin
					len_q <= du_rsp.result[29:0];
				end
			end
			ST_MU0: begin
				if (len_q == '0) begin
					mu_q <= '0;
				end
			end
			ST_MU: begin
				if (du_rsp.done) begin
					mu_q <= (du_rsp.result > 52'(ONE_Q)) ? ONE_Q : du_rsp.result[COL_W-1:0];
				end
			end
			ST_SHADE: begin
				if (ph_q) begin
					shade_q[row_q] <= mul_q[32:16];
				end
			end
			ST_PJ0: begin
				neg_q <= num[51] ^ den[34];
				if (den == '0) begin
					if (num == '0) begin
						proj_q[ci_q] <= '0;
					end else begin
						proj_q[ci_q] <= num[51] ? 32'sh8000_0000 : 32'sh7fff_ffff;
					end
				end
			end
			ST_PJW: begin
				if (du_rsp.done) begin
					proj_q[ci_q] <= q_sat;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					o_x_q <= proj_q[0];
					o_y_q <= proj_q[1];
					o_z_q <= proj_q[2];
					o_r_q <= shade_q[0];
					o_g_q <= shade_q[1];
					o_b_q <= shade_q[2];
					o_last_q <= (vi_q == 2'd2);
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			term_q <= '0;
			vi_q <= '0;
			ci_q <= '0;
			ph_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[0] <= 32'(ONE_Q);
			coef_q[5] <= 32'(ONE_Q);
			coef_q[10] <= 32'(ONE_Q);
			color_q[0] <= ONE_Q;
			color_q[1] <= ONE_Q;
			color_q[2] <= ONE_Q;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RED: color_q[0] <= cfg_wdata;
					CFG_GREEN: color_q[1] <= cfg_wdata;
					CFG_BLUE: color_q[2] <= cfg_wdata;
					default: ;
				endcase
			end
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					term_q <= '0;
					ph_q <= 1'b0;
					if (accept) begin
						case (items.kind)
							KIND_COEF: begin
								if (items.index_a < IDX_W'(NUM_COEF)) begin
									coef_q[items.index_a[3:0]] <= items.value_x;
								end
							end
							KIND_VERTEX: state_q <= ST_VMUL;
							KIND_FACE: state_q <= ST_FETCH;
							default: ;
						endcase
					end
				end
				ST_VMUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (term_q == 2'd2) begin
							term_q <= '0;
							row_q <= row_q + 1'b1;
							if (row_q == 2'd2) begin
								state_q <= ST_VWR;
							end
						end else begin
							term_q <= term_q + 1'b1;
						end
					end
				end
				ST_VWR: state_q <= ST_IDLE;
				ST_FETCH: begin
					row_q <= row_q + 1'b1;
					if (row_q == 2'd3) begin
						row_q <= '0;
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					state_q <= ST_CROSS;
					ph_q <= 1'b0;
					term_q <= '0;
				end
				ST_CROSS: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						term_q <= {1'b0, !term_q[0]};
						if (term_q[0]) begin
							row_q <= row_q + 1'b1;
							if (row_q == 2'd2) begin
								row_q <= '0;
								state_q <= ST_NORM;
							end
						end
					end
				end
				ST_NORM: begin
					if (fits_all) begin
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						row_q <= row_q + 1'b1;
						if (row_q == 2'd2) begin
							row_q <= '0;
							state_q <= (sum_full > 66'sd0) ? ST_SQ : ST_IDLE;
						end
					end
				end
				ST_SQ: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						row_q <= row_q + 1'b1;
						if (row_q == 2'd2) begin
							row_q <= '0;
							state_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (du_rsp.done) begin
						state_q <= ST_MU0;
					end
				end
				ST_MU0: state_q <= (len_q == '0) ? ST_SHADE : ST_MU;
				ST_MU: begin
					if (du_rsp.done) begin
						state_q <= ST_SHADE;
					end
				end
				ST_SHADE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						row_q <= row_q + 1'b1;
						if (row_q == 2'd2) begin
							row_q <= '0;
							vi_q <= '0;
							ci_q <= '0;
							state_q <= ST_PJ0;
						end
					end
				end
				ST_PJ0: begin
					if (den != '0) begin
						state_q <= ST_PJW;
					end else if (ci_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				ST_PJW: begin
					if (du_rsp.done) begin
						if (ci_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							ci_q <= ci_q + 1'b1;
							state_q <= ST_PJ0;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ci_q <= '0;
						if (vi_q == 2'd2) begin
							state_q <= ST_IDLE;
						end else begin
							vi_q <= vi_q + 1'b1;
							state_q <= ST_PJ0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid = out_valid_q;
	assign results.proj_x = o_x_q;
	assign results.proj_y = o_y_q;
	assign results.proj_z = o_z_q;
	assign results.shade_red = o_r_q;
	assign results.shade_green = o_g_q;
	assign results.shade_blue = o_b_q;
	assign results.last_vertex = o_last_q;

	`BFC_NEVER(a_start_busy, clk, arst_n, du_req.start && du_rsp.busy)
	`BFC_ASSERT(a_norm_fit, clk, arst_n, (state_q == ST_DOT) |-> fits_all)
	`BFC_ASSERT(a_done_wait, clk, arst_n, du_rsp.done |-> (state_q == ST_SQRT || state_q == ST_MU || state_q == ST_PJW))
endmodule
`default_nettype wire

/* verif/bfc_scoreboard.sv */
// Checker that predicts the shaded vertices of every accepted visible face and compares the block's results.
`default_nettype none
module bfc_scoreboard import bfc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	bfc_item_if items,
	bfc_result_if results,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [COL_W-1:0] cfg_wdata,
	output int errors,
	output int pending,
	output int faces_drawn,
	output int faces_culled
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [VAL_W-1:0] px;
		logic signed [VAL_W-1:0] py;
		logic signed [VAL_W-1:0] pz;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic last;
	} shaded_vertex_t;

	shaded_vertex_t vertex_q[$];
	logic signed [VAL_W-1:0] coef[NUM_COEF];
	logic signed [VAL_W-1:0] wx[VERTEX_DEPTH];
	logic signed [VAL_W-1:0] wy[VERTEX_DEPTH];
	logic signed [VAL_W-1:0] wz[VERTEX_DEPTH];
	logic [COL_W-1:0] col_r, col_g, col_b;

	assign pending = vertex_q.size();

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint row_map(int k, longint x, longint y, longint z);
		longint s;
		s = ((longint'(coef[4*k]) * x) >>> 16) + ((longint'(coef[4*k+1]) * y) >>> 16)
			+ ((longint'(coef[4*k+2]) * z) >>> 16) + longint'(coef[4*k+3]);
		return clip32(s);
	endfunction

	function automatic longint project(longint num, longint den);
		if (den == 0) begin
			if (num > 0) return 64'sd2147483647;
			if (num < 0) return -64'sd2147483648;
			return 0;
		end
		return clip32(num / den);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic shade_face(logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib, logic [IDX_W-1:0] ic);
		longint v[3][3];
		longint u[3], w[3], e[3], n[3];
		logic signed [65:0] a[3], b[3], c[3];
		logic [IDX_W-1:0] idx[3];
		longint dotv, len, mu, nz, den;
		longint unsigned sq;
		shaded_vertex_t sv;
		idx[0] = ia;
		idx[1] = ib;
		idx[2] = ic;
		for (int i = 0; i < 3; i++) begin
			v[i][0] = wx[idx[i]];
			v[i][1] = wy[idx[i]];
			v[i][2] = wz[idx[i]];
		end
		for (int i = 0; i < 3; i++) begin
			u[i] = clip32(v[1][i] - v[0][i]);
			w[i] = clip32(v[2][i] - v[0][i]);
			a[i] = u[i];
			b[i] = w[i];
		end
		e[0] = clip32(-v[0][0]);
		e[1] = clip32(-v[0][1]);
		e[2] = clip32(5 * 65536 - v[0][2]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		while (!(c[0] < 66'sd536870912 && c[0] >= -66'sd536870912
			&& c[1] < 66'sd536870912 && c[1] >= -66'sd536870912
			&& c[2] < 66'sd536870912 && c[2] >= -66'sd536870912)) begin
			for (int i = 0; i < 3; i++) c[i] = c[i] >>> 1;
		end
		for (int i = 0; i < 3; i++) n[i] = longint'(c[i]);
		dotv = n[0] * e[0] + n[1] * e[1] + n[2] * e[2];
		if (dotv <= 0) begin
			faces_culled++;
			return;
		end
		faces_drawn++;
		sq = longint'(n[0] * n[0]) + longint'(n[1] * n[1]) + longint'(n[2] * n[2]);
		len = longint'(root_floor(sq));
		nz = n[2] < 0 ? -n[2] : n[2];
		mu = len == 0 ? 0 : (nz * 65536) / len;
		if (mu > 65536) mu = 65536;
		for (int i = 0; i < 3; i++) begin
			den = 10 * 65536 - 2 * v[i][2];
			sv.px = VAL_W'(project(11 * v[i][0] * 65536, den));
			sv.py = VAL_W'(project(11 * v[i][1] * 65536, den));
			sv.pz = VAL_W'(project((v[i][2] - 5 * 65536) * 65536, den));
			sv.red = COL_W'((longint'(col_r) * mu) >> 16);
			sv.green = COL_W'((longint'(col_g) * mu) >> 16);
			sv.blue = COL_W'((longint'(col_b) * mu) >> 16);
			sv.last = (i == 2);
			vertex_q.push_back(sv);
		end
	endtask

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	initial begin
		errors = 0;
		faces_drawn = 0;
		faces_culled = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		shaded_vertex_t ev;
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) coef[i] <= '0;
			coef[0] <= 32'sd65536;
			coef[5] <= 32'sd65536;
			coef[10] <= 32'sd65536;
			col_r <= ONE_Q;
			col_g <= ONE_Q;
			col_b <= ONE_Q;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RED: col_r = cfg_wdata;
					CFG_GREEN: col_g = cfg_wdata;
					CFG_BLUE: col_b = cfg_wdata;
					default: ;
				endcase
			end
			if (items.valid && items.ready) begin
				case (items.kind)
					KIND_COEF: if (items.index_a < NUM_COEF) coef[items.index_a] = items.value_x;
					KIND_VERTEX: begin
						wx[items.index_a] = VAL_W'(row_map(0, items.value_x, items.value_y,
							items.value_z));
						wy[items.index_a] = VAL_W'(row_map(1, items.value_x, items.value_y,
							items.value_z));
						wz[items.index_a] = VAL_W'(row_map(2, items.value_x, items.value_y,
							items.value_z));
					end
					KIND_FACE: shade_face(items.index_a, items.index_b, items.index_c);
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (vertex_q.size() == 0) begin
					report("unexpected result", results.proj_x, 0);
				end else begin
					ev = vertex_q.pop_front();
					if (results.proj_x !== ev.px) report("proj_x", results.proj_x, ev.px);
					if (results.proj_y !== ev.py) report("proj_y", results.proj_y, ev.py);
					if (results.proj_z !== ev.pz) report("proj_z", results.proj_z, ev.pz);
					if (results.shade_red !== ev.red)
						report("shade_red", results.shade_red, ev.red);
					if (results.shade_green !== ev.green)
						report("shade_green", results.shade_green, ev.green);
					if (results.shade_blue !== ev.blue)
						report("shade_blue", results.shade_blue, ev.blue);
					if (results.last_vertex !== ev.last)
						report("last_vertex", results.last_vertex, ev.last);
				end
			end
		end
	end
endmodule
`default_nettype wire

/* verif/backface_cull_flat_shade_top_tb.sv */
// Testbench top: drives transform, vertex and face items with random idling and gives the verdict.
`default_nettype none
module backface_cull_flat_shade_top_tb;
	import bfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COL_W-1:0] cfg_wdata;
	int errors, pending, faces_drawn, faces_culled;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int slots[$];
	bit written[VERTEX_DEPTH];

	bfc_item_if items();
	bfc_result_if results();

	backface_cull_flat_shade_top uut (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	bfc_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .faces_drawn(faces_drawn),
		.faces_culled(faces_culled)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The receiver idles in short bursts and once holds off for a long stretch.
	initial begin
		int n;
		results.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				results.ready <= 1'b0;
				for (int i = 0; i < 3000; i++) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				results.ready <= 1'b0;
				n = $urandom_range(1, 13);
				repeat (n) @(posedge clk);
			end else begin
				results.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send(logic [1:0] kind, logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
		logic [IDX_W-1:0] ic, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bit ok;
		int n;
		items.valid <= 1'b1;
		items.kind <= kind;
		items.index_a <= ia;
		items.index_b <= ib;
		items.index_c <= ic;
		items.value_x <= x;
		items.value_y <= y;
		items.value_z <= z;
		do begin
			@(negedge clk);
			ok = items.ready;
			@(posedge clk);
		end while (!ok);
		items_sent++;
		if (kind == KIND_VERTEX && !written[ia]) begin
			written[ia] = 1'b1;
			slots.push_back(ia);
		end
		if (!calm && $urandom_range(0, 4) == 0) begin
			items.valid <= 1'b0;
			n = $urandom_range(1, 13);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic set_colors(logic [COL_W-1:0] r, logic [COL_W-1:0] g, logic [COL_W-1:0] b);
		items.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RED;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_index <= CFG_GREEN;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= CFG_BLUE;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] coord();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 524288)) - 262144);
	endfunction

	task automatic random_item();
		int r;
		logic [IDX_W-1:0] ia;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			ia = $urandom_range(0, NUM_COEF - 1);
			if ($urandom_range(0, 7) == 0) v = $urandom;
			else if (ia == 0 || ia == 5 || ia == 10) v = $urandom_range(40000, 90000);
			else v = 32'($signed($urandom_range(0, 65536)) - 32768);
			send(KIND_COEF, ia, $urandom, $urandom, v, $urandom, $urandom);
		end else if (r < 45 || slots.size() < 3) begin
			ia = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 31);
			send(KIND_VERTEX, ia, $urandom, $urandom, coord(), coord(), coord());
		end else if (r < 95) begin
			send(KIND_FACE, slots[$urandom_range(0, slots.size() - 1)],
				slots[$urandom_range(0, slots.size() - 1)],
				slots[$urandom_range(0, slots.size() - 1)], $urandom, $urandom, $urandom);
		end else if (r < 98) begin
			send(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			send(KIND_COEF, $urandom_range(NUM_COEF, 1023), $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end
	endtask

	initial begin
		items.valid <= 1'b0;
		items.kind <= KIND_COEF;
		items.index_a <= '0;
		items.index_b <= '0;
		items.index_c <= '0;
		items.value_x <= '0;
		items.value_y <= '0;
		items.value_z <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_RED;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(KIND_VERTEX, 0, 0, 0, 0, 0, 0);
		send(KIND_VERTEX, 1, 0, 0, 32'd65536, 0, 0);
		send(KIND_VERTEX, 2, 0, 0, 0, 32'd65536, 0);
		send(KIND_FACE, 0, 1, 2, 0, 0, 0);
		send(KIND_FACE, 0, 2, 1, 0, 0, 0);
		send(KIND_FACE, 0, 0, 1, 0, 0, 0);
		send(KIND_VERTEX, 3, 0, 0, 32'd65536, 32'hffff_0000, 32'd327680);
		send(KIND_FACE, 0, 1, 3, 0, 0, 0);
		send(KIND_VERTEX, 4, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		send(KIND_VERTEX, 1023, 1023, 1023, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send(KIND_FACE, 4, 1023, 0, 0, 0, 0);
		send(KIND_FACE, 1023, 4, 2, 0, 0, 0);
		send(KIND_UNUSED, 1023, 1023, 1023, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send(KIND_COEF, 1023, 0, 0, 32'hffff_ffff, 0, 0);
		send(KIND_COEF, 3, 0, 0, 32'h7fff_ffff, 0, 0);
		send(KIND_VERTEX, 5, 0, 0, 32'd65536, 32'd65536, 32'd65536);
		send(KIND_COEF, 3, 0, 0, 0, 0, 0);
		send(KIND_COEF, 0, 0, 0, 32'h8000_0000, 0, 0);
		send(KIND_VERTEX, 6, 0, 0, 32'h7fff_ffff, 32'd131072, 0);
		send(KIND_COEF, 0, 0, 0, 32'd65536, 0, 0);
		send(KIND_FACE, 5, 6, 2, 0, 0, 0);
		send(KIND_FACE, 3, 2, 1, 0, 0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_colors(17'd0, ONE_Q, 17'h1ffff);
				1: set_colors($urandom_range(0, 65536), $urandom_range(0, 65536),
					$urandom_range(0, 65536));
				2: set_colors(17'h1ffff, 17'd0, ONE_Q);
				default: set_colors($urandom, $urandom, $urandom);
			endcase
			for (int k = 0; k < 85; k++) begin
				if (phase == 1 && k == 10) hold_req = 1'b1;
				if (phase == 2 && k == 40) begin
					items.valid <= 1'b0;
					while (pending != 0) @(posedge clk);
				end
				if (phase == 3 && k == 40) calm = 1'b1;
				random_item();
			end
		end
		items.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items over four color settings; %0d faces drawn, %0d faces culled.",
			items_sent, faces_drawn, faces_culled);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/bfc_pkg.sv
rtl/bfc_if.sv
rtl/bfc_vstore.sv
rtl/bfc_divsqrt.sv
rtl/backface_cull_flat_shade_top.sv
verif/bfc_scoreboard.sv
verif/backface_cull_flat_shade_top_tb.sv
